@@ hw/rtl/isp_pkg.sv @@
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types and constants for the idle slot pool: field widths, command
// codes and the control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package isp_pkg;

    // Fixed field widths of the word interface
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 10;
    localparam int RANGE_W = 11;
    localparam int STAMP_W = 32;

    // Command codes carried by the input word
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_FIND   = 2'd3
    } t_cmd;

    // Which source the result register loads from
    typedef enum logic [1:0] {
        OUT_ECHO = 2'd0,
        OUT_READ = 2'd1,
        OUT_FIND = 2'd2
    } t_out_sel;

    // Controller to datapath
    typedef struct packed {
        logic     take;   // input word accepted this cycle
        logic     issue;  // scan read of the current counter slot
        logic     clear;  // clearing-pass write of the current counter slot
        logic     load;   // load the result register
        t_out_sel sel;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_more;  // counter still inside the search range
        logic clear_last; // counter at the final slot of the clearing pass
        logic pipe_empty; // no scan read in flight
    } t_ctrl_sts;

endpackage

`default_nettype wire

@@ hw/rtl/idle_slot_pool_oldest_pick.sv @@
// Insert and remove: the result register loads as the word is accepted; read: it
// loads from the S_READ state. Find: slots range_low up to the clamped range_high,
// one slot read per cycle through each table's single read port, then a two-stage
// compare drain; an empty range goes straight to the drain.
// One word is in work at a time; the next is accepted once the result is taken.
// After reset a clearing pass zeroes the valid table, with no word accepted meanwhile.
// ----------------------------------------------------------------------------
// idle_slot_pool_oldest_pick
// Slot table with insert, remove, read and a range search for the valid,
// inactive slot idle longest beyond a minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module idle_slot_pool_oldest_pick #(
    parameter int NUM_SLOTS = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [isp_pkg::CMD_W-1:0]    i_command,
    input  wire logic [isp_pkg::SLOT_W-1:0]   i_slot,
    input  wire logic                         i_active,
    input  wire logic [isp_pkg::STAMP_W-1:0]  i_stamp_ms,
    input  wire logic [isp_pkg::RANGE_W-1:0]  i_range_low,
    input  wire logic [isp_pkg::RANGE_W-1:0]  i_range_high,
    input  wire logic [isp_pkg::STAMP_W-1:0]  i_min_idle_ms,
    input  wire logic [isp_pkg::STAMP_W-1:0]  i_now_ms,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_ok,
    output logic [isp_pkg::SLOT_W-1:0]        o_slot_out,
    output logic                              o_active_out,
    output logic [isp_pkg::STAMP_W-1:0]       o_stamp_out
);
    import isp_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_ctrl_sts ctrl_sts;

    // Sequencing
    isp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_cmd     (ctrl_cmd),
        .i_sts     (ctrl_sts)
    );

    // Tables and search
    isp_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .o_sts         (ctrl_sts),
        .i_command     (i_command),
        .i_slot        (i_slot),
        .i_active      (i_active),
        .i_stamp_ms    (i_stamp_ms),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_min_idle_ms (i_min_idle_ms),
        .i_now_ms      (i_now_ms),
        .o_ok          (o_ok),
        .o_slot_out    (o_slot_out),
        .o_active_out  (o_active_out),
        .o_stamp_out   (o_stamp_out)
    );

endmodule

`default_nettype wire

@@ hw/rtl/isp_dp.sv @@
// ----------------------------------------------------------------------------
// isp_dp
// Datapath: slot tables, scan counter, idle-time compare pipeline, best-slot
// tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_dp #(
    parameter int NUM_SLOTS = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire isp_pkg::t_ctrl_cmd           i_cmd,
    output isp_pkg::t_ctrl_sts                o_sts,
    input  wire logic [isp_pkg::CMD_W-1:0]    i_command,
    input  wire logic [isp_pkg::SLOT_W-1:0]   i_slot,
    input  wire logic                         i_active,
    input  wire logic [isp_pkg::STAMP_W-1:0]  i_stamp_ms,
    input  wire logic [isp_pkg::RANGE_W-1:0]  i_range_low,
    input  wire logic [isp_pkg::RANGE_W-1:0]  i_range_high,
    input  wire logic [isp_pkg::STAMP_W-1:0]  i_min_idle_ms,
    input  wire logic [isp_pkg::STAMP_W-1:0]  i_now_ms,
    output logic                              o_ok,
    output logic [isp_pkg::SLOT_W-1:0]        o_slot_out,
    output logic                              o_active_out,
    output logic [isp_pkg::STAMP_W-1:0]       o_stamp_out
);
    import isp_pkg::*;

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    // counter wide enough for both the range fields and the table size
    localparam int SCAN_W = (IDX_W + 1 > RANGE_W) ? IDX_W + 1 : RANGE_W;
    localparam logic [SCAN_W-1:0] NUM_SLOTS_W = SCAN_W'(NUM_SLOTS);
    localparam logic [SCAN_W-1:0] LAST_SLOT_W = SCAN_W'(NUM_SLOTS - 1);

    // Slot tables
    logic               mem_valid [NUM_SLOTS];
    logic [STAMP_W:0]   mem_data  [NUM_SLOTS]; // {active, stamp}

    // Item registers
    logic [SCAN_W-1:0]  r_cnt;
    logic [SCAN_W-1:0]  r_hi;
    logic [STAMP_W-1:0] r_min;
    logic [STAMP_W-1:0] r_now;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_in_table;

    // Read data
    logic               r_rd_valid;
    logic               r_rd_act;
    logic [STAMP_W-1:0] r_rd_stamp;

    // Compare pipeline
    logic               r_p1_v;
    logic [SCAN_W-1:0]  r_p1_idx;
    logic               r_p2_v;
    logic               r_p2_ok;
    logic [SCAN_W-1:0]  r_p2_idx;
    logic [STAMP_W-1:0] r_p2_idle;
    logic [STAMP_W-1:0] r_p2_stamp;

    // Best so far
    logic               r_found;
    logic [SCAN_W-1:0]  r_best_idx;
    logic [STAMP_W-1:0] r_best_idle;
    logic [STAMP_W-1:0] r_best_stamp;

    logic [SCAN_W-1:0]  slot_ext;
    logic [IDX_W-1:0]   slot_idx;
    logic [IDX_W-1:0]   cnt_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               in_table;
    logic [SCAN_W-1:0]  hi_ext;
    logic [SCAN_W-1:0]  hi_clamp;
    logic               wr_valid_en;
    logic               wr_valid_bit;
    logic               wr_data_en;
    logic               better;

    // Address and range decode
    always_comb begin
        slot_ext = SCAN_W'(i_slot);
        slot_idx = slot_ext[IDX_W-1:0];
        cnt_idx  = r_cnt[IDX_W-1:0];
        in_table = (slot_ext < NUM_SLOTS_W);
        hi_ext   = SCAN_W'(i_range_high);
        hi_clamp = (hi_ext > NUM_SLOTS_W) ? NUM_SLOTS_W : hi_ext;
        rd_addr  = i_cmd.issue ? cnt_idx : slot_idx;
        wr_addr  = i_cmd.clear ? cnt_idx : slot_idx;
    end

    // Table write enables
    always_comb begin
        wr_valid_en  = 1'b0;
        wr_valid_bit = 1'b0;
        wr_data_en   = 1'b0;
        if (i_cmd.clear) begin
            wr_valid_en = 1'b1;
        end else if (i_cmd.take && in_table) begin
            if (i_command == CMD_INSERT) begin
                wr_valid_en  = 1'b1;
                wr_valid_bit = 1'b1;
                wr_data_en   = 1'b1;
            end else if (i_command == CMD_REMOVE) begin
                wr_valid_en = 1'b1;
            end
        end
    end

    // Valid table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_valid_en) begin
            mem_valid[wr_addr] <= wr_valid_bit;
        end
        r_rd_valid <= mem_valid[rd_addr];
    end

    // Entry table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_data_en) begin
            mem_data[wr_addr] <= {i_active, i_stamp_ms};
        end
        {r_rd_act, r_rd_stamp} <= mem_data[rd_addr];
    end

    // Counter and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_cnt <= SCAN_W'(i_range_low);
            end else if (i_cmd.issue || i_cmd.clear) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_p1_v <= i_cmd.issue;
            r_p2_v <= r_p1_v;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_hi       <= hi_clamp;
            r_min      <= i_min_idle_ms;
            r_now      <= i_now_ms;
            r_slot     <= i_slot;
            r_in_table <= in_table;
        end
    end

    // Idle time stage
    always_ff @(posedge i_clk) begin
        r_p1_idx   <= r_cnt;
        r_p2_ok    <= r_p1_v && r_rd_valid && !r_rd_act;
        r_p2_idx   <= r_p1_idx;
        r_p2_idle  <= r_now - r_rd_stamp;
        r_p2_stamp <= r_rd_stamp;
    end

    // Best slot: strictly larger wins, so the lower index keeps a tie
    assign better = r_p2_v && r_p2_ok && (r_p2_idle > r_min) && (r_p2_idle > r_best_idle);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.take) begin
            r_found <= 1'b0;
        end else if (better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_best_idle <= '0;
        end else if (better) begin
            r_best_idle  <= r_p2_idle;
            r_best_idx   <= r_p2_idx;
            r_best_stamp <= r_p2_stamp;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            case (i_cmd.sel)
                OUT_READ: begin
                    o_ok         <= r_in_table && r_rd_valid;
                    o_slot_out   <= r_slot;
                    o_active_out <= (r_in_table && r_rd_valid) ? r_rd_act : 1'b0;
                    o_stamp_out  <= (r_in_table && r_rd_valid) ? r_rd_stamp : '0;
                end
                OUT_FIND: begin
                    o_ok         <= r_found;
                    o_slot_out   <= r_found ? r_best_idx[SLOT_W-1:0] : '0;
                    o_active_out <= 1'b0;
                    o_stamp_out  <= r_found ? r_best_stamp : '0;
                end
                default: begin
                    o_ok         <= 1'b0;
                    o_slot_out   <= i_slot;
                    o_active_out <= 1'b0;
                    o_stamp_out  <= '0;
                end
            endcase
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.scan_more  = (r_cnt < r_hi);
        o_sts.clear_last = (r_cnt == LAST_SLOT_W);
        o_sts.pipe_empty = !r_p1_v && !r_p2_v;
    end

endmodule

`default_nettype wire

@@ hw/rtl/isp_ctrl.sv @@
// ----------------------------------------------------------------------------
// isp_ctrl
// Controller: clearing pass after reset, word acceptance, scan sequencing and
// the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [isp_pkg::CMD_W-1:0]  i_command,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output isp_pkg::t_ctrl_cmd              o_cmd,
    input  wire isp_pkg::t_ctrl_sts         i_sts
);
    import isp_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DRAIN = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   accept;

    // Result slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_cmd.sel = OUT_ECHO;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.take = 1'b1;
                    unique case (t_cmd'(i_command))
                        CMD_INSERT, CMD_REMOVE: begin
                            o_cmd.load = 1'b1;
                        end
                        CMD_READ: begin
                            n_state = S_READ;
                        end
                        CMD_FIND: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.load = 1'b1;
                o_cmd.sel  = OUT_READ;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                if (i_sts.scan_more) begin
                    o_cmd.issue = 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = OUT_FIND;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: a load wins over a take in the same cycle
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: idle slot pool testbench
// Drives insert, remove, read and find words into the slot table, tracks the
// table contents in a local predictor and checks every result word, field by
// field and in order. Directed corner cases come first, then random traffic
// around a moving window of slots, a stretch without idling, and a period of
// long receiver back-pressure.
// ----------------------------------------------------------------------------

module tb_top;
    import isp_pkg::*;

    localparam int NUM_SLOTS   = 1024;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 16;
    localparam int CYCLE_LIMIT = 5_000_000;

    typedef struct packed {
        t_cmd                 cmd;
        logic [SLOT_W-1:0]    slot;
        logic                 active;
        logic [STAMP_W-1:0]   stamp_ms;
        logic [RANGE_W-1:0]   range_low;
        logic [RANGE_W-1:0]   range_high;
        logic [STAMP_W-1:0]   min_idle_ms;
        logic [STAMP_W-1:0]   now_ms;
    } t_pool_req;

    typedef struct packed {
        logic                 ok;
        logic [SLOT_W-1:0]    slot_out;
        logic                 active_out;
        logic [STAMP_W-1:0]   stamp_out;
    } t_pool_rsp;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [CMD_W-1:0]     i_command = '0;
    logic [SLOT_W-1:0]    i_slot = '0;
    logic                 i_active = 1'b0;
    logic [STAMP_W-1:0]   i_stamp_ms = '0;
    logic [RANGE_W-1:0]   i_range_low = '0;
    logic [RANGE_W-1:0]   i_range_high = '0;
    logic [STAMP_W-1:0]   i_min_idle_ms = '0;
    logic [STAMP_W-1:0]   i_now_ms = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_ok;
    logic [SLOT_W-1:0]    o_slot_out;
    logic                 o_active_out;
    logic [STAMP_W-1:0]   o_stamp_out;

    // Predictor copy of the slot table
    bit                   pool_valid  [NUM_SLOTS];
    bit                   pool_active [NUM_SLOTS];
    logic [STAMP_W-1:0]   pool_stamp  [NUM_SLOTS];

    t_pool_rsp            pending_answers [$];
    int                   fail_count = 0;
    int                   cycle_count = 0;
    bit                   quiet_mode = 1'b0;
    bit                   hold_request = 1'b0;
    int                   hold_left = 0;

    // Random traffic state: window of busy slots, running ms clock, tie stamp
    int unsigned          win_base = 0;
    logic [STAMP_W-1:0]   now_clock = '0;
    logic [STAMP_W-1:0]   tie_stamp = '0;

    idle_slot_pool_oldest_pick #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_slot        (i_slot),
        .i_active      (i_active),
        .i_stamp_ms    (i_stamp_ms),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_min_idle_ms (i_min_idle_ms),
        .i_now_ms      (i_now_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_ok          (o_ok),
        .o_slot_out    (o_slot_out),
        .o_active_out  (o_active_out),
        .o_stamp_out   (o_stamp_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** idle_slot_pool_oldest_pick: FAILED **");
            $finish;
        end
    end

    // Receiver: random stalls, or a long counted hold when requested
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(99) < 19) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Works out the answer to one word and updates the table copy
    function automatic t_pool_rsp predict_pool_answer(input t_pool_req w);
        t_pool_rsp          r;
        int                 n;
        int                 top;
        logic [STAMP_W-1:0] idle;
        logic [STAMP_W-1:0] best_idle;
        r.ok         = 1'b0;
        r.slot_out   = w.slot;
        r.active_out = 1'b0;
        r.stamp_out  = '0;
        case (w.cmd)
            CMD_INSERT: begin
                pool_valid[w.slot]  = 1'b1;
                pool_active[w.slot] = w.active;
                pool_stamp[w.slot]  = w.stamp_ms;
            end
            CMD_REMOVE: begin
                pool_valid[w.slot] = 1'b0;
            end
            CMD_READ: begin
                if (pool_valid[w.slot]) begin
                    r.ok         = 1'b1;
                    r.active_out = pool_active[w.slot];
                    r.stamp_out  = pool_stamp[w.slot];
                end
            end
            default: begin
                // find: largest idle time wins, first index on a tie
                top = (int'(w.range_high) > NUM_SLOTS) ? NUM_SLOTS : int'(w.range_high);
                best_idle  = '0;
                r.slot_out = '0;
                for (n = int'(w.range_low); n < top; n++) begin
                    if (pool_valid[n] && !pool_active[n]) begin
                        idle = w.now_ms - pool_stamp[n];
                        if (idle > w.min_idle_ms && idle > best_idle) begin
                            best_idle   = idle;
                            r.ok        = 1'b1;
                            r.slot_out  = SLOT_W'(n);
                            r.stamp_out = pool_stamp[n];
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_pool_req build_request(
        input t_cmd               cmd,
        input logic [SLOT_W-1:0]  slot,
        input logic               active,
        input logic [STAMP_W-1:0] stamp_ms,
        input logic [RANGE_W-1:0] range_low,
        input logic [RANGE_W-1:0] range_high,
        input logic [STAMP_W-1:0] min_idle_ms,
        input logic [STAMP_W-1:0] now_ms
    );
        t_pool_req w;
        w.cmd         = cmd;
        w.slot        = slot;
        w.active      = active;
        w.stamp_ms    = stamp_ms;
        w.range_low   = range_low;
        w.range_high  = range_high;
        w.min_idle_ms = min_idle_ms;
        w.now_ms      = now_ms;
        return w;
    endfunction

    // Mostly inserts and short finds around the window, some noise
    function automatic t_pool_req random_request();
        t_pool_req   w;
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        now_clock = now_clock + $urandom_range(0, 40);
        pick = $urandom_range(99);
        if (pick < 38)
            w.cmd = CMD_INSERT;
        else if (pick < 48)
            w.cmd = CMD_REMOVE;
        else if (pick < 65)
            w.cmd = CMD_READ;
        else
            w.cmd = CMD_FIND;
        w.slot = ($urandom_range(99) < 10) ? SLOT_W'($urandom_range(0, NUM_SLOTS - 1)) :
                 SLOT_W'(win_base + $urandom_range(0, 63));
        w.active = ($urandom_range(0, 2) == 0);
        pick = $urandom_range(99);
        w.stamp_ms = (pick < 15) ? $urandom :
                     (pick < 35) ? tie_stamp : now_clock - $urandom_range(0, 300);
        pick = $urandom_range(99);
        if (pick < 3) begin
            lo = 0;
            hi = NUM_SLOTS;
        end else if (pick < 12) begin
            lo = $urandom_range(0, NUM_SLOTS);
            hi = $urandom_range(0, NUM_SLOTS);
        end else begin
            lo = win_base + $urandom_range(0, 40);
            hi = win_base + $urandom_range(0, 72);
            if (hi > NUM_SLOTS)
                hi = NUM_SLOTS;
        end
        w.range_low  = RANGE_W'(lo);
        w.range_high = RANGE_W'(hi);
        pick = $urandom_range(99);
        w.min_idle_ms = (pick < 45) ? '0 : (pick < 85) ? $urandom_range(0, 200) : $urandom;
        w.now_ms = ($urandom_range(99) < 10) ? $urandom : now_clock;
        return w;
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_word(input t_pool_req w);
        if (!quiet_mode && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 19);
        end
        i_valid       <= 1'b1;
        i_command     <= w.cmd;
        i_slot        <= w.slot;
        i_active      <= w.active;
        i_stamp_ms    <= w.stamp_ms;
        i_range_low   <= w.range_low;
        i_range_high  <= w.range_high;
        i_min_idle_ms <= w.min_idle_ms;
        i_now_ms      <= w.now_ms;
        do @(posedge i_clk); while (!o_ready);
        pending_answers.push_back(predict_pool_answer(w));
    endtask

    // Drop valid and wait for every outstanding answer
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 48 == 0) begin
                win_base  = $urandom_range(0, NUM_SLOTS - 64);
                tie_stamp = now_clock - $urandom_range(0, 300);
            end
            send_word(random_request());
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_pool_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected result word: slot_out %0d", o_slot_out);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                check_field("ok", 32'(want.ok), 32'(o_ok));
                check_field("slot_out", 32'(want.slot_out), 32'(o_slot_out));
                check_field("active_out", 32'(want.active_out), 32'(o_active_out));
                check_field("stamp_out", want.stamp_out, o_stamp_out);
            end
        end
    end

    // Corners: wrap of the idle time, ties, strict minimum, empty ranges
    task automatic test_directed();
        send_word(build_request(CMD_READ,   10'd0,    1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd0, 11'd1024, 32'd0, 32'd0));
        send_word(build_request(CMD_INSERT, 10'd0,    1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_INSERT, 10'd1023, 1'b0, 32'hFFFF_FFFF,
                                11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_INSERT, 10'd5,    1'b1, 32'h1234_5678,
                                11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_READ,   10'd0,    1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_READ,   10'd1023, 1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_READ,   10'd5,    1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0));
        // idle of the all-ones stamp wraps to 1 at time 0
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd0, 11'd1024, 32'd0, 32'd0));
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd0, 11'd1024,
                                32'd0, 32'd100));
        send_word(build_request(CMD_INSERT, 10'd10,   1'b0, 32'd1000, 11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_INSERT, 10'd20,   1'b0, 32'd1000, 11'd0, 11'd0, 32'd0, 32'd0));
        // equal idle: lower slot wins
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd10, 11'd21,
                                32'd0, 32'd2000));
        // idle equal to the minimum is not enough
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd10, 11'd21,
                                32'd1000, 32'd2000));
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd10, 11'd21,
                                32'd999, 32'd2000));
        // empty ranges, then a range of the last slot alone
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd21, 11'd10,
                                32'd0, 32'd2000));
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd1024, 11'd1024,
                                32'd0, 32'd2000));
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd1023, 11'd1024,
                                32'd0, 32'd5));
        // removed slot drops out of read and find
        send_word(build_request(CMD_REMOVE, 10'd10,   1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_READ,   10'd10,   1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd10, 11'd21,
                                32'd0, 32'd2000));
        send_word(build_request(CMD_INSERT, 10'd10,   1'b1, 32'hFFFF_FFFF,
                                11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_READ,   10'd10,   1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_FIND,   10'd0,    1'b0, 32'd0, 11'd0, 11'd1024,
                                32'hFFFF_FFFF, 32'd2000));
        send_word(build_request(CMD_REMOVE, 10'd5,    1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0));
        send_word(build_request(CMD_READ,   10'd5,    1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0));
        // unused fields at their extremes on an insert
        send_word(build_request(CMD_INSERT, 10'd682,  1'b0, 32'hAAAA_AAAA, 11'd1024, 11'd1024,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_random_mix();
        now_clock = $urandom;
        send_random(360);
    endtask

    // Neither side idles for a long run of words
    task automatic test_steady_flow();
        quiet_mode = 1'b1;
        send_random(150);
        quiet_mode = 1'b0;
    endtask

    // Receiver holds off while words keep coming, then sender waits for drain
    task automatic test_backpressure();
        hold_request = 1'b1;
        send_random(25);
        wait_drained();
        send_random(20);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_mix();
        test_steady_flow();
        test_backpressure();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("** idle_slot_pool_oldest_pick: PASSED **");
        else
            $display("** idle_slot_pool_oldest_pick: FAILED **");
        $finish;
    end

endmodule
